[hw/rtl/spc_pkg.sv]
`timescale 1ns / 1ps
// Package for the stepper position controller: item kinds, register indexes,
// motor state struct and reset constants. No dependencies.
package spc_pkg;

    localparam int PHASE_COUNT_DEF = 8;
    localparam int COIL_BITS_DEF   = 8;

    localparam logic [63:0] PHASE_TABLE_RST   = 64'h0;
    localparam logic [15:0] STEPS_PER_REV_RST = 16'd4096;
    localparam logic [15:0] MIN_REV           = 16'd2;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_MOVE = 2'd1,
        KIND_HOME = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_PHASE_TABLE   = 1'b0,
        CFG_STEPS_PER_REV = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] position;
        logic [15:0] goal;
        logic        running;
        logic        backward;
        logic        slot_seen;
    } t_motor_state;

endpackage

[hw/rtl/spc_step_unit.sv]
`timescale 1ns / 1ps
// Next-state logic for one item: half step with index fix, move and home
// commands, and coil pattern pick. Depends on spc_pkg.
module spc_step_unit #(
    parameter int PHASE_COUNT = spc_pkg::PHASE_COUNT_DEF,
    parameter int COIL_BITS   = spc_pkg::COIL_BITS_DEF
) (
    input  spc_pkg::t_motor_state i_cur,
    input  logic [1:0]            i_kind,
    input  logic                  i_level,
    input  logic [15:0]           i_target,
    input  logic                  i_obvious,
    input  logic [63:0]           i_phase_table,
    input  logic [15:0]           i_steps_per_rev,
    output spc_pkg::t_motor_state o_next,
    output logic [7:0]            o_coil,
    output logic                  o_taken
);
    import spc_pkg::*;

    localparam logic [2:0] PH_LAST   = 3'(PHASE_COUNT - 1);
    localparam logic [7:0] COIL_MASK = 8'((9'd1 << COIL_BITS) - 9'd1);

    logic [15:0]  rev;
    logic [15:0]  rev_last;
    logic [16:0]  pos_inc;
    logic [16:0]  dist_w;
    logic [15:0]  fwd_dist;
    logic [15:0]  clamp_tgt;
    t_motor_state stp;

    assign rev       = (i_steps_per_rev < MIN_REV) ? MIN_REV : i_steps_per_rev;
    assign rev_last  = rev - 16'd1;
    assign pos_inc   = {1'b0, i_cur.position} + 17'd1;
    assign clamp_tgt = (i_target > rev_last) ? rev_last : i_target;
    assign dist_w    = ((i_cur.position > clamp_tgt) ? ({1'b0, clamp_tgt} + {1'b0, rev})
                                                     : {1'b0, clamp_tgt})
                       - {1'b0, i_cur.position};
    assign fwd_dist  = dist_w[15:0];

    // one half step
    always_comb begin
        stp = i_cur;
        if (!i_cur.backward) begin
            stp.phase    = (i_cur.phase >= PH_LAST) ? 3'd0 : i_cur.phase + 3'd1;
            stp.position = (pos_inc >= {1'b0, rev}) ? 16'd0 : pos_inc[15:0];
        end else begin
            stp.phase    = (i_cur.phase == 3'd0) ? PH_LAST : i_cur.phase - 3'd1;
            stp.position = (i_cur.position == 16'd0) ? rev_last : i_cur.position - 16'd1;
        end
        if (i_level && !i_cur.slot_seen && !i_cur.backward) begin
            if (i_cur.goal > stp.position) begin
                stp.goal = 16'd0;
            end
            stp.position = 16'd0;
        end
        if (!i_level && i_cur.slot_seen && i_cur.backward) begin
            stp.position = rev_last;
            if (i_cur.goal >= rev) begin
                stp.goal = rev_last;
            end
        end
        stp.slot_seen = i_level;
        if (stp.position == stp.goal) begin
            stp.running = 1'b0;
        end
    end

    always_comb begin
        o_next  = i_cur;
        o_taken = 1'b0;
        case (t_kind'(i_kind))
            KIND_TICK: begin
                if (i_cur.running) begin
                    o_next = stp;
                end
            end
            KIND_MOVE: begin
                if (!i_cur.running) begin
                    o_taken         = 1'b1;
                    o_next.goal     = clamp_tgt;
                    o_next.running  = (clamp_tgt != i_cur.position);
                    o_next.backward = i_obvious && (clamp_tgt != i_cur.position)
                                      && (fwd_dist < (rev >> 1));
                end
            end
            KIND_HOME: begin
                o_taken          = 1'b1;
                o_next.backward  = 1'b0;
                o_next.running   = 1'b1;
                o_next.slot_seen = i_level;
                o_next.goal      = 16'd0;
            end
            default: begin
                o_next  = i_cur;
                o_taken = 1'b0;
            end
        endcase
    end

    assign o_coil = i_phase_table[{o_next.phase, 3'b000} +: 8] & COIL_MASK;

endmodule

[hw/rtl/stepper_position_controller_core.sv]
`timescale 1ns / 1ps
// Top level of the stepper position controller: item and result handshakes,
// configuration registers and motor state. Depends on spc_pkg, spc_step_unit.
//
// Each accepted item (tick, move or home) gives exactly one result beat in the
// next cycle: coil pattern, position, moving, reverse and whether a command was
// taken. One item is accepted every cycle while the input does not stall; the
// rate is set by the update of the motor state register. The input stalls only
// while a result is held and the output side stalls. Configuration writes are
// always ready and should be made while no item is in flight. No startup pass.
module stepper_position_controller_core #(
    parameter int PHASE_COUNT = spc_pkg::PHASE_COUNT_DEF,
    parameter int COIL_BITS   = spc_pkg::COIL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic        i_sensor_level,
    input  logic [15:0] i_target,
    input  logic        i_obvious,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_coil_pattern,
    output logic [15:0] o_position,
    output logic        o_moving,
    output logic        o_reverse,
    output logic        o_accepted,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import spc_pkg::*;

    t_motor_state r_st;
    t_motor_state n_st;
    logic [63:0]  r_phase_table;
    logic [15:0]  r_steps_per_rev;
    logic         r_out_valid;
    logic [7:0]   r_coil;
    logic         r_taken;
    logic [7:0]   n_coil;
    logic         n_taken;
    logic         in_acc;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    spc_step_unit #(
        .PHASE_COUNT (PHASE_COUNT),
        .COIL_BITS   (COIL_BITS)
    ) u_step (
        .i_cur           (r_st),
        .i_kind          (i_kind),
        .i_level         (i_sensor_level),
        .i_target        (i_target),
        .i_obvious       (i_obvious),
        .i_phase_table   (r_phase_table),
        .i_steps_per_rev (r_steps_per_rev),
        .o_next          (n_st),
        .o_coil          (n_coil),
        .o_taken         (n_taken)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_table   <= PHASE_TABLE_RST;
            r_steps_per_rev <= STEPS_PER_REV_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PHASE_TABLE:   r_phase_table   <= i_cfg_data;
                CFG_STEPS_PER_REV: r_steps_per_rev <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_st <= n_st;
            end
            r_out_valid <= in_acc || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_coil  <= n_coil;
            r_taken <= n_taken;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_coil_pattern = r_coil;
    assign o_position     = r_st.position;
    assign o_moving       = r_st.running;
    assign o_reverse      = r_st.backward;
    assign o_accepted     = r_taken;

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result held");

    a_stopped_at_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.running |-> r_st.position == r_st.goal)
        else $error("motor stopped away from its goal");

    a_tick_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_kind == KIND_TICK) |=> o_out_valid && !o_accepted)
        else $error("tick beat reported as taken");

endmodule
